// File: rtl/ssec_pkg.sv
// ----------------------------------------------------------------------------
// ssec_pkg
// Shared types and constants of the sleep stage epoch classifier.
// ----------------------------------------------------------------------------
package ssec_pkg;

  // epoch history depth and derived widths
  localparam int unsigned HISTORY_EPOCHS = 10;
  localparam int unsigned HIST_PTR_W     = $clog2(HISTORY_EPOCHS);
  localparam int unsigned HIST_FILL_W    = $clog2(HISTORY_EPOCHS + 1);
  localparam int unsigned HIST_TOT_W     = $clog2(HISTORY_EPOCHS * 255 + 1);

  // payload widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned HR_W    = 8;
  localparam int unsigned ACC_W   = 16;
  localparam int unsigned STAGE_W = 2;
  localparam int unsigned VAR_W   = 12;
  localparam int unsigned MOV_W   = 8;

  // configuration port
  localparam int unsigned THR_W      = 13;
  localparam int unsigned LIMIT_W    = 8;
  localparam int unsigned DDELTA_W   = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [THR_W-1:0]           THR_RESET   = 13'd410;
  localparam logic [LIMIT_W-1:0]         AWAKE_RESET = 8'd15;
  localparam logic [LIMIT_W-1:0]         REM_RESET   = 8'd3;
  localparam logic signed [DDELTA_W-1:0] DDELTA_RESET = -7'sd5;

  // arithmetic constants
  localparam int unsigned ONE_G         = 4096;
  localparam int unsigned DELTA_W       = 10;
  localparam logic signed [DELTA_W-1:0] REM_DELTA_MIN = -10'sd2;
  localparam int unsigned RMS_SQ_LIMIT  = 9;   // 3.0 squared
  localparam int unsigned DEEP_MOV_MAX  = 1;
  localparam int unsigned VAR_MAX       = 4095;

  // shared unit
  localparam int unsigned DVD_W      = 32;
  localparam int unsigned DIVISOR_W  = 8;
  localparam int unsigned SUB_W      = 33;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned SQR_LAST   = 5;
  localparam int unsigned SQ_W       = 17;

  typedef enum logic [OP_W-1:0] {
    OP_HR    = 2'd0,
    OP_ACCEL = 2'd1,
    OP_EPOCH = 2'd2
  } op_e;

  typedef enum logic [STAGE_W-1:0] {
    STAGE_AWAKE = 2'd0,
    STAGE_LIGHT = 2'd1,
    STAGE_DEEP  = 2'd2,
    STAGE_REM   = 2'd3
  } stage_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_AWAKE_LIMIT = 2'd1,
    CFG_REM_LIMIT   = 2'd2,
    CFG_DEEP_DELTA  = 2'd3
  } cfg_idx_e;

endpackage

// File: rtl/ssec_if.sv
// ----------------------------------------------------------------------------
// ssec_if
// Valid/ready channels of the sleep stage epoch classifier.
// ----------------------------------------------------------------------------
interface ssec_in_if;
  logic                               valid;
  logic                               ready;
  logic [ssec_pkg::OP_W-1:0]          operation;
  logic [ssec_pkg::HR_W-1:0]          heart_rate;
  logic signed [ssec_pkg::ACC_W-1:0]  accel_x;
  logic signed [ssec_pkg::ACC_W-1:0]  accel_y;
  logic signed [ssec_pkg::ACC_W-1:0]  accel_z;

  modport source (
    output valid, operation, heart_rate, accel_x, accel_y, accel_z,
    input  ready
  );
  modport sink (
    input  valid, operation, heart_rate, accel_x, accel_y, accel_z,
    output ready
  );
endinterface

interface ssec_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssec_pkg::STAGE_W-1:0]  stage;
  logic [ssec_pkg::HR_W-1:0]     average_rate;
  logic [ssec_pkg::VAR_W-1:0]    variability;
  logic [ssec_pkg::MOV_W-1:0]    movements;

  modport source (
    output valid, stage, average_rate, variability, movements,
    input  ready
  );
  modport sink (
    input  valid, stage, average_rate, variability, movements,
    output ready
  );
endinterface

// File: rtl/sleep_stage_epoch_classifier_unit.sv
// ----------------------------------------------------------------------------
// sleep_stage_epoch_classifier_unit
// Per-epoch heart rate, movement and sleep stage classification.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries heart rate samples, accelerometer samples and epoch-end
//   ticks; result_o carries one classification per epoch-end tick. Both use
//   valid/ready, a transaction completes when both are high at a clock edge.
//   Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
//   must do so only while idle, which the block itself does not enforce.
//   The block handles one transaction at a time and drops ready meanwhile:
//     heart rate sample: one multiply, one accumulate
//     accel sample: five squares through one multiplier
//     epoch end: three 32-step divisions, a 16-step square root, one subtractor
//   ready returns in the same cycle that the result is loaded into the output
//   register. If the receiver stalls, a result waits there while further
//   samples are taken; a following epoch end holds in its last step until
//   the output register is free.
//   Reset (rst_ni low) clears the epoch accumulators and the history, restores
//   the register defaults and starts a new session.
// ----------------------------------------------------------------------------
module sleep_stage_epoch_classifier_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ssec_in_if.sink                           item_i,
  ssec_out_if.source                        result_o,
  input  logic                              cfg_we_i,
  input  logic [ssec_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ssec_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SQR   = 6'b000010,
    S_ACC   = 6'b000100,
    S_DIV   = 6'b001000,
    S_SQRT  = 6'b010000,
    S_CLASS = 6'b100000
  } state_e;

  localparam int unsigned HE = ssec_pkg::HISTORY_EPOCHS;

  state_e state_q, state_d;
  logic [ssec_pkg::STEP_W-1:0] step_q;
  logic [1:0]                  dsel_q;

  // configuration
  logic [ssec_pkg::THR_W-1:0]           thr_q;
  logic [ssec_pkg::LIMIT_W-1:0]         awake_lim_q;
  logic [ssec_pkg::LIMIT_W-1:0]         rem_lim_q;
  logic signed [ssec_pkg::DDELTA_W-1:0] deep_delta_q;

  // epoch and session state
  logic [ssec_pkg::MOV_W-1:0]        mov_cnt_q;
  logic [7:0]                        rate_cnt_q;
  logic [15:0]                       rate_sum_q;
  logic [ssec_pkg::HR_W-1:0]         prev_rate_q;
  logic [23:0]                       sds_q;
  logic [ssec_pkg::HIST_TOT_W-1:0]   hist_total_q;
  logic [ssec_pkg::HIST_FILL_W-1:0]  hist_fill_q;
  logic [ssec_pkg::HIST_PTR_W-1:0]   hist_ptr_q;
  logic [ssec_pkg::HR_W-1:0]         hist_mem_q [HE];
  logic [ssec_pkg::HR_W-1:0]         hist_rd_q;

  // latched transaction
  logic [ssec_pkg::OP_W-1:0]         op_q;
  logic [ssec_pkg::HR_W-1:0]         hr_q;
  logic signed [ssec_pkg::ACC_W-1:0] ax_q, ay_q, az_q;

  // shared datapath
  logic [31:0]                        prod_q, mag2_q, hi2_q, lo2_q;
  logic [ssec_pkg::DVD_W-1:0]         dvd_q;
  logic [ssec_pkg::DIVISOR_W-1:0]     rem_q, divisor_q;
  logic [31:0]                        sres_q, sbit_q;
  logic [ssec_pkg::HR_W-1:0]          avg_q, recent_q;

  // output register
  logic                              out_valid_q;
  ssec_pkg::stage_e                  out_stage_q;
  logic [ssec_pkg::HR_W-1:0]         out_avg_q;
  logic [ssec_pkg::VAR_W-1:0]        out_var_q;
  logic [ssec_pkg::MOV_W-1:0]        out_mov_q;

  logic in_acc, out_free, hist_full, hist_we, moved;

  // ---------------------------------------------------------------------------
  // shared squarer
  // ---------------------------------------------------------------------------
  logic [ssec_pkg::HR_W-1:0]   hr_diff;
  logic [13:0]                 hi_val;
  logic [ssec_pkg::THR_W-1:0]  lo_val;
  logic signed [ssec_pkg::SQ_W-1:0] sq_in;
  logic signed [33:0]          sq_prod;

  assign hr_diff = (hr_q > prev_rate_q) ? (hr_q - prev_rate_q) : (prev_rate_q - hr_q);
  assign hi_val  = 14'(ssec_pkg::ONE_G) + 14'(thr_q);
  assign lo_val  = ssec_pkg::THR_W'(ssec_pkg::ONE_G) - thr_q;

  always_comb begin
    if (op_q == ssec_pkg::OP_HR) begin
      sq_in = {9'b0, hr_diff};
    end else begin
      case (step_q)
        5'd0:    sq_in = {ax_q[15], ax_q};
        5'd1:    sq_in = {ay_q[15], ay_q};
        5'd2:    sq_in = {az_q[15], az_q};
        5'd3:    sq_in = {3'b0, hi_val};
        5'd4:    sq_in = {4'b0, lo_val};
        default: sq_in = '0;
      endcase
    end
  end

  assign sq_prod = sq_in * sq_in;

  assign moved = (mag2_q > hi2_q) ||
                 ((thr_q < ssec_pkg::THR_W'(ssec_pkg::ONE_G)) && (mag2_q < lo2_q));

  // ---------------------------------------------------------------------------
  // shared compare/subtract unit, used for division and square root steps
  // ---------------------------------------------------------------------------
  logic [ssec_pkg::DIVISOR_W:0]  rem_sh;
  logic [ssec_pkg::SUB_W-1:0]    sub_a, sub_b;
  logic [ssec_pkg::SUB_W:0]      sub_diff;
  logic                          sub_ge;
  logic [ssec_pkg::DVD_W-1:0]    quot_nx;

  assign rem_sh = {rem_q, dvd_q[ssec_pkg::DVD_W-1]};

  always_comb begin
    if (state_q == S_SQRT) begin
      sub_a = {1'b0, dvd_q};
      sub_b = {1'b0, sres_q | sbit_q};
    end else begin
      sub_a = ssec_pkg::SUB_W'(rem_sh);
      sub_b = ssec_pkg::SUB_W'(divisor_q);
    end
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_diff[ssec_pkg::SUB_W];
  assign quot_nx  = {dvd_q[ssec_pkg::DVD_W-2:0], sub_ge};

  // ---------------------------------------------------------------------------
  // classification
  // ---------------------------------------------------------------------------
  logic [7:0]                         n1;
  logic [11:0]                        nine_n1;
  logic                               var_high;
  logic [ssec_pkg::HR_W-1:0]          recent_use;
  logic signed [ssec_pkg::DELTA_W-1:0] delta, deep_ext;
  logic [ssec_pkg::VAR_W-1:0]         var_val;
  ssec_pkg::stage_e                   stage;

  assign n1       = rate_cnt_q - 8'd1;
  assign nine_n1  = 12'(n1) * 12'(ssec_pkg::RMS_SQ_LIMIT);
  assign var_high = (rate_cnt_q >= 8'd2) && (sds_q > 24'(nine_n1));
  assign hist_full  = (hist_fill_q >= ssec_pkg::HIST_FILL_W'(HE));
  assign recent_use = hist_full ? recent_q : avg_q;
  assign delta    = $signed({2'b0, avg_q}) - $signed({2'b0, recent_use});
  assign deep_ext = {{(ssec_pkg::DELTA_W-ssec_pkg::DDELTA_W){deep_delta_q[6]}}, deep_delta_q};

  always_comb begin
    if (rate_cnt_q < 8'd2) begin
      var_val = '0;
    end else if (sres_q > 32'(ssec_pkg::VAR_MAX)) begin
      var_val = ssec_pkg::VAR_W'(ssec_pkg::VAR_MAX);
    end else begin
      var_val = sres_q[ssec_pkg::VAR_W-1:0];
    end
  end

  always_comb begin
    if (mov_cnt_q >= awake_lim_q) begin
      stage = ssec_pkg::STAGE_AWAKE;
    end else if ((avg_q != '0) && (recent_use != '0)) begin
      if ((mov_cnt_q <= ssec_pkg::MOV_W'(ssec_pkg::DEEP_MOV_MAX)) && (delta <= deep_ext)) begin
        stage = ssec_pkg::STAGE_DEEP;
      end else if ((mov_cnt_q <= rem_lim_q) && var_high &&
                   (delta >= ssec_pkg::REM_DELTA_MIN)) begin
        stage = ssec_pkg::STAGE_REM;
      end else begin
        stage = ssec_pkg::STAGE_LIGHT;
      end
    end else if (mov_cnt_q <= ssec_pkg::MOV_W'(ssec_pkg::DEEP_MOV_MAX)) begin
      stage = ssec_pkg::STAGE_DEEP;
    end else begin
      stage = ssec_pkg::STAGE_LIGHT;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign item_i.ready = (state_q == S_IDLE);
  assign in_acc       = item_i.valid && (state_q == S_IDLE);
  assign out_free     = !out_valid_q || result_o.ready;
  assign hist_we      = (state_q == S_CLASS) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (item_i.operation)
            ssec_pkg::OP_HR: begin
              if ((item_i.heart_rate != '0) && (rate_cnt_q != 8'hFF)) state_d = S_SQR;
            end
            ssec_pkg::OP_ACCEL: state_d = S_SQR;
            ssec_pkg::OP_EPOCH: state_d = S_DIV;
            default:            state_d = S_IDLE;
          endcase
        end
      end
      S_SQR: begin
        if ((op_q == ssec_pkg::OP_HR) || (step_q == ssec_pkg::STEP_W'(ssec_pkg::SQR_LAST))) begin
          state_d = S_ACC;
        end
      end
      S_ACC:  state_d = S_IDLE;
      S_DIV: begin
        if ((step_q == ssec_pkg::STEP_W'(ssec_pkg::DIV_STEPS-1)) && (dsel_q == 2'd2)) begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (step_q == ssec_pkg::STEP_W'(ssec_pkg::SQRT_STEPS-1)) state_d = S_CLASS;
      end
      S_CLASS: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      dsel_q       <= '0;
      thr_q        <= ssec_pkg::THR_RESET;
      awake_lim_q  <= ssec_pkg::AWAKE_RESET;
      rem_lim_q    <= ssec_pkg::REM_RESET;
      deep_delta_q <= ssec_pkg::DDELTA_RESET;
      mov_cnt_q    <= '0;
      rate_cnt_q   <= '0;
      rate_sum_q   <= '0;
      prev_rate_q  <= '0;
      sds_q        <= '0;
      hist_total_q <= '0;
      hist_fill_q  <= '0;
      hist_ptr_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          ssec_pkg::CFG_THRESHOLD:   thr_q        <= cfg_data_i;
          ssec_pkg::CFG_AWAKE_LIMIT: awake_lim_q  <= cfg_data_i[ssec_pkg::LIMIT_W-1:0];
          ssec_pkg::CFG_REM_LIMIT:   rem_lim_q    <= cfg_data_i[ssec_pkg::LIMIT_W-1:0];
          ssec_pkg::CFG_DEEP_DELTA:  deep_delta_q <= $signed(cfg_data_i[ssec_pkg::DDELTA_W-1:0]);
          default: ;
        endcase
      end

      if (out_valid_q && result_o.ready) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          step_q <= '0;
          dsel_q <= '0;
        end
        S_SQR: step_q <= step_q + 1'b1;
        S_ACC: begin
          step_q <= '0;
          if (op_q == ssec_pkg::OP_HR) begin
            if (rate_cnt_q != '0) sds_q <= sds_q + 24'(prod_q[15:0]);
            rate_sum_q  <= rate_sum_q + 16'(hr_q);
            rate_cnt_q  <= rate_cnt_q + 8'd1;
            prev_rate_q <= hr_q;
          end else if (moved && (mov_cnt_q != '1)) begin
            mov_cnt_q <= mov_cnt_q + 1'b1;
          end
        end
        S_DIV: begin
          if (step_q == ssec_pkg::STEP_W'(ssec_pkg::DIV_STEPS-1)) begin
            step_q <= '0;
            dsel_q <= dsel_q + 2'd1;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_SQRT: begin
          if (step_q == ssec_pkg::STEP_W'(ssec_pkg::SQRT_STEPS-1)) step_q <= '0;
          else step_q <= step_q + 1'b1;
        end
        S_CLASS: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (hist_full) begin
              hist_total_q <= ssec_pkg::HIST_TOT_W'(
                  {1'b0, hist_total_q} - (ssec_pkg::HIST_TOT_W+1)'(hist_rd_q)
                  + (ssec_pkg::HIST_TOT_W+1)'(avg_q));
            end else begin
              hist_total_q <= hist_total_q + ssec_pkg::HIST_TOT_W'(avg_q);
              hist_fill_q  <= hist_fill_q + 1'b1;
            end
            if (hist_ptr_q == ssec_pkg::HIST_PTR_W'(HE-1)) hist_ptr_q <= '0;
            else hist_ptr_q <= hist_ptr_q + 1'b1;
            mov_cnt_q   <= '0;
            rate_cnt_q  <= '0;
            rate_sum_q  <= '0;
            prev_rate_q <= '0;
            sds_q       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_q      <= item_i.operation;
          hr_q      <= item_i.heart_rate;
          ax_q      <= item_i.accel_x;
          ay_q      <= item_i.accel_y;
          az_q      <= item_i.accel_z;
          dvd_q     <= ssec_pkg::DVD_W'(rate_sum_q);
          rem_q     <= '0;
          divisor_q <= rate_cnt_q;
        end
      end
      S_SQR: begin
        prod_q <= sq_prod[31:0];
        if (step_q == 5'd0) mag2_q <= '0;
        else if (step_q <= 5'd3) mag2_q <= mag2_q + prod_q;
        if (step_q == 5'd4) hi2_q <= prod_q;
        if (step_q == 5'd5) lo2_q <= prod_q;
      end
      S_DIV: begin
        rem_q <= sub_ge ? sub_diff[ssec_pkg::DIVISOR_W-1:0] : rem_sh[ssec_pkg::DIVISOR_W-1:0];
        dvd_q <= quot_nx;
        if (step_q == ssec_pkg::STEP_W'(ssec_pkg::DIV_STEPS-1)) begin
          rem_q <= '0;
          case (dsel_q)
            2'd0: begin
              avg_q     <= (rate_cnt_q == '0) ? '0 : quot_nx[ssec_pkg::HR_W-1:0];
              dvd_q     <= ssec_pkg::DVD_W'(hist_total_q);
              divisor_q <= ssec_pkg::DIVISOR_W'(HE);
            end
            2'd1: begin
              recent_q  <= quot_nx[ssec_pkg::HR_W-1:0];
              dvd_q     <= {sds_q, 8'b0};
              divisor_q <= n1;
            end
            default: begin
              // quotient stays in dvd_q as the radicand
              sres_q <= '0;
              sbit_q <= 32'h4000_0000;
            end
          endcase
        end
      end
      S_SQRT: begin
        if (sub_ge) begin
          dvd_q  <= sub_diff[31:0];
          sres_q <= (sres_q >> 1) | sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      S_CLASS: begin
        if (out_free) begin
          out_stage_q <= stage;
          out_avg_q   <= avg_q;
          out_var_q   <= var_val;
          out_mov_q   <= mov_cnt_q;
        end
      end
      default: ;
    endcase
  end

  // epoch history memory, registered read of the entry about to be replaced
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem_q[hist_ptr_q] <= avg_q;
    hist_rd_q <= hist_mem_q[hist_ptr_q];
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.stage        = out_stage_q;
  assign result_o.average_rate = out_avg_q;
  assign result_o.variability  = out_var_q;
  assign result_o.movements    = out_mov_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_empty_epoch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rate_cnt_q == '0) |-> ((rate_sum_q == '0) && (sds_q == '0)))
    else $error("rate accumulators nonzero with no samples");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_CLASS))
    else $error("result raised outside classification step");

  a_hist_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hist_fill_q < ssec_pkg::HIST_FILL_W'(HE)) |->
      (hist_ptr_q == ssec_pkg::HIST_PTR_W'(hist_fill_q)))
    else $error("history pointer out of step with fill count");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the sleep stage epoch classifier. A directed table of samples
// and epoch ends runs first, then random epochs under several register
// settings. Results are checked against a local stage predictor or typed rows.
// ----------------------------------------------------------------------------
module tb;
  import ssec_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned G_UNIT        = 4096;
  localparam int unsigned HIST_DEPTH    = 10;
  localparam int unsigned RMS_LIMIT_SQ  = 9;
  localparam int          REM_DELTA_MIN = -2;
  localparam int unsigned DEEP_MOVE_MAX = 1;
  localparam int unsigned COUNT_MAX     = 255;
  localparam int unsigned HRV_MAX       = 4095;

  localparam int RANDOM_ITEMS   = 1600;
  localparam int PHASES         = 6;
  localparam int SETTLE_CYCLES  = 16;
  localparam int END_CYCLES     = 250;
  localparam int HOLD_AFTER     = 12;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [HR_W-1:0]  hr;
    logic [ACC_W-1:0] ax;
    logic [ACC_W-1:0] ay;
    logic [ACC_W-1:0] az;
  } sample_t;

  typedef struct packed {
    stage_e             stage;
    logic [HR_W-1:0]    rate;
    logic [VAR_W-1:0]   hrv;
    logic [MOV_W-1:0]   moves;
  } epoch_res_t;

  typedef struct packed {
    sample_t    s;
    logic       typed;
    epoch_res_t res;
  } dir_row_t;

  typedef enum int {ACC_STILL, ACC_EDGE, ACC_WILD} accel_kind_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ssec_in_if  item_bus ();
  ssec_out_if result_bus ();

  sleep_stage_epoch_classifier_unit DUT (
    .clk_i,
    .rst_ni,
    .item_i     (item_bus),
    .result_o   (result_bus),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of registers and epoch state
  logic [THR_W-1:0]           thr_reg    = 13'd410;
  logic [LIMIT_W-1:0]         awake_lim  = 8'd15;
  logic [LIMIT_W-1:0]         rem_lim    = 8'd3;
  logic signed [DDELTA_W-1:0] deep_delta = -7'sd5;

  int unsigned moves = 0;
  int unsigned rate_n = 0;
  int unsigned rate_total = 0;
  int unsigned rate_last = 0;
  int unsigned diff_sq_total = 0;
  int unsigned epoch_rates [HIST_DEPTH];
  int unsigned rates_total = 0;
  int unsigned rates_filled = 0;
  int unsigned rates_wr = 0;

  epoch_res_t expected_epochs [$];
  epoch_res_t want;
  dir_row_t   dir_rows [$];

  int  errors = 0;
  int  items_done = 0;
  int  stim_count = 0;
  int  results_seen = 0;
  int  settings_used = 0;
  int  stall_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  no_idle = 1'b0;
  int  hr_base = 70;

  function automatic int unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return int'(root);
  endfunction

  function automatic bit stage_predict(input sample_t s, output epoch_res_t r);
    longint      ax, ay, az, mag2, hi, lo;
    int unsigned d, avg, hrv, recent, n1;
    int          delta;
    bit          moved, var_high;
    r = '0;
    if (s.op == OP_HR) begin
      if (s.hr != '0 && rate_n < COUNT_MAX) begin
        if (rate_n >= 1) begin
          d = (s.hr > rate_last) ? s.hr - rate_last : rate_last - s.hr;
          diff_sq_total += d * d;
        end
        rate_total += s.hr;
        rate_n++;
        rate_last = s.hr;
      end
      return 1'b0;
    end
    if (s.op == OP_ACCEL) begin
      ax = longint'($signed(s.ax));
      ay = longint'($signed(s.ay));
      az = longint'($signed(s.az));
      mag2 = ax * ax + ay * ay + az * az;
      hi = longint'(G_UNIT) + longint'(thr_reg);
      moved = mag2 > hi * hi;
      // lower test only exists while the band stays above zero g
      if (thr_reg < G_UNIT) begin
        lo = longint'(G_UNIT) - longint'(thr_reg);
        if (mag2 < lo * lo) moved = 1'b1;
      end
      if (moved && moves < COUNT_MAX) moves++;
      return 1'b0;
    end
    if (s.op != OP_EPOCH) return 1'b0;

    avg = (rate_n != 0) ? rate_total / rate_n : 0;
    hrv = 0;
    var_high = 1'b0;
    if (rate_n >= 2) begin
      n1 = rate_n - 1;
      hrv = floor_sqrt((longint'(diff_sq_total) << 8) / longint'(n1));
      if (hrv > HRV_MAX) hrv = HRV_MAX;
      var_high = diff_sq_total > RMS_LIMIT_SQ * n1;
    end
    recent = (rates_filled >= HIST_DEPTH) ? rates_total / HIST_DEPTH : avg;

    if (moves >= awake_lim) begin
      r.stage = STAGE_AWAKE;
    end else if (avg > 0 && recent > 0) begin
      delta = int'(avg) - int'(recent);
      if (moves <= DEEP_MOVE_MAX && delta <= int'(deep_delta)) r.stage = STAGE_DEEP;
      else if (moves <= rem_lim && var_high && delta >= REM_DELTA_MIN) r.stage = STAGE_REM;
      else r.stage = STAGE_LIGHT;
    end else if (moves <= DEEP_MOVE_MAX) begin
      r.stage = STAGE_DEEP;
    end else begin
      r.stage = STAGE_LIGHT;
    end

    if (rates_filled >= HIST_DEPTH) rates_total -= epoch_rates[rates_wr];
    else rates_filled++;
    rates_total += avg;
    epoch_rates[rates_wr] = avg;
    rates_wr = (rates_wr + 1) % HIST_DEPTH;

    r.rate  = avg[HR_W-1:0];
    r.hrv   = hrv[VAR_W-1:0];
    r.moves = moves[MOV_W-1:0];
    moves = 0;
    rate_n = 0;
    rate_total = 0;
    rate_last = 0;
    diff_sq_total = 0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // result side: check each transaction, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      results_seen++;
      if (expected_epochs.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, stage %0d rate %0d hrv %0d moves %0d",
                 $time, result_bus.stage, result_bus.average_rate,
                 result_bus.variability, result_bus.movements);
      end else begin
        want = expected_epochs.pop_front();
        check_field("stage", want.stage, result_bus.stage);
        check_field("average_rate", want.rate, result_bus.average_rate);
        check_field("variability", want.hrv, result_bus.variability);
        check_field("movements", want.moves, result_bus.movements);
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else if (!hold_done && results_seen == HOLD_AFTER) begin
      // long hold-off so the block backs up into its input
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= no_idle || ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input sample_t s, input logic typed, input epoch_res_t typed_res);
    epoch_res_t r;
    if (!no_idle && $urandom_range(99) < 10) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    item_bus.valid      <= 1'b1;
    item_bus.operation  <= s.op;
    item_bus.heart_rate <= s.hr;
    item_bus.accel_x    <= s.ax;
    item_bus.accel_y    <= s.ay;
    item_bus.accel_z    <= s.az;
    do @(posedge clk_i); while (!item_bus.ready);
    items_done++;
    if (stage_predict(s, r)) expected_epochs.push_back(typed ? typed_res : r);
  endtask

  task automatic drain_results(input bit settle);
    item_bus.valid <= 1'b0;
    do @(posedge clk_i); while (expected_epochs.size() != 0);
    // accel or rate work may still be in flight
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] awk,
                               input logic [CFG_DATA_W-1:0] rem, input logic [CFG_DATA_W-1:0] dd);
    cfg_idx_e              order [4];
    logic [CFG_DATA_W-1:0] vals  [4];
    order = '{CFG_THRESHOLD, CFG_AWAKE_LIMIT, CFG_REM_LIMIT, CFG_DEEP_DELTA};
    vals  = '{thr, awk, rem, dd};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= order[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      case (order[i])
        CFG_THRESHOLD:   thr_reg    = vals[i][THR_W-1:0];
        CFG_AWAKE_LIMIT: awake_lim  = vals[i][LIMIT_W-1:0];
        CFG_REM_LIMIT:   rem_lim    = vals[i][LIMIT_W-1:0];
        CFG_DEEP_DELTA:  deep_delta = vals[i][DDELTA_W-1:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input int hr, input int x, input int y,
                         input int z, input logic typed, input stage_e st, input int rate,
                         input int hrv, input int mv);
    dir_row_t row;
    row.s     = '{op, 8'(hr), 16'(x), 16'(y), 16'(z)};
    row.typed = typed;
    row.res   = '{st, 8'(rate), 12'(hrv), 8'(mv)};
    dir_rows.push_back(row);
  endtask

  function automatic sample_t junk_item(input logic [OP_W-1:0] op);
    sample_t s;
    s.op = op;
    s.hr = 8'($urandom);
    s.ax = 16'($urandom);
    s.ay = 16'($urandom);
    s.az = 16'($urandom);
    return s;
  endfunction

  function automatic sample_t rate_item(input int jitter);
    sample_t s;
    int      v;
    s = junk_item(OP_HR);
    v = hr_base + int'($urandom_range(0, 2 * jitter)) - jitter;
    if (v < 1) v = 1;
    if (v > 255) v = 255;
    s.hr = 8'(v);
    return s;
  endfunction

  function automatic sample_t accel_item(input accel_kind_e kind);
    sample_t s;
    int      v;
    s = junk_item(OP_ACCEL);
    if (kind == ACC_STILL) begin
      s.ax = 16'(int'($urandom_range(0, 400)) - 200);
      s.ay = 16'(int'($urandom_range(0, 400)) - 200);
      v = int'(G_UNIT) + int'($urandom_range(0, 300)) - 150;
      if ($urandom_range(1) == 1) v = -v;
      s.az = 16'(v);
    end else if (kind == ACC_EDGE) begin
      // one axis sitting on a band edge, give or take one count
      if ($urandom_range(1) == 1 || thr_reg >= G_UNIT) v = int'(G_UNIT) + int'(thr_reg);
      else v = int'(G_UNIT) - int'(thr_reg);
      v = v + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(1) == 1) v = -v;
      s.ax = '0;
      s.ay = '0;
      s.az = '0;
      case ($urandom_range(0, 2))
        0:       s.ax = 16'(v);
        1:       s.ay = 16'(v);
        default: s.az = 16'(v);
      endcase
    end
    return s;
  endfunction

  task automatic send_epoch(input bit long_rates, input bit long_moves);
    int unsigned n_hr, n_acc, move_pct;
    int          jitter;
    sample_t     s;
    accel_kind_e kind;
    // baseline drifts, sometimes drops sharply and later recovers
    if ($urandom_range(99) < 15) hr_base -= int'($urandom_range(5, 15));
    else if ($urandom_range(99) < 10) hr_base += int'($urandom_range(5, 20));
    else hr_base += int'($urandom_range(0, 4)) - 2;
    if (hr_base < 35) hr_base = 35;
    if (hr_base > 200) hr_base = 200;
    n_hr  = long_rates ? $urandom_range(256, 290) : $urandom_range(0, 24);
    n_acc = long_moves ? $urandom_range(256, 290) : $urandom_range(0, 24);
    case ($urandom_range(0, 3))
      0:       move_pct = 0;
      1:       move_pct = 5;
      2:       move_pct = 30;
      default: move_pct = 100;
    endcase
    if (long_moves) move_pct = 100;
    jitter = int'($urandom_range(0, 8));
    while (n_hr + n_acc > 0) begin
      if ($urandom_range(99) < 6) begin
        case ($urandom_range(0, 2))
          0: s = junk_item(OP_UNUSED);
          1: begin
            s = junk_item(OP_HR);
            s.hr = '0;
          end
          default: s = junk_item(OP_HR);
        endcase
        send_item(s, 1'b0, '0);
      end else if ($urandom_range(0, n_hr + n_acc - 1) < n_hr) begin
        send_item(rate_item(jitter), 1'b0, '0);
        n_hr--;
        stim_count++;
      end else begin
        kind = ($urandom_range(99) < move_pct) ? ACC_WILD :
               (($urandom_range(0, 3) == 0) ? ACC_EDGE : ACC_STILL);
        send_item(accel_item(kind), 1'b0, '0);
        n_acc--;
        stim_count++;
      end
    end
    send_item(junk_item(OP_EPOCH), 1'b0, '0);
    stim_count++;
  endtask

  initial begin
    int goal;
    bit first;
    item_bus.valid      = 1'b0;
    item_bus.operation  = '0;
    item_bus.heart_rate = '0;
    item_bus.accel_x    = '0;
    item_bus.accel_y    = '0;
    item_bus.accel_z    = '0;
    result_bus.ready    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty epoch right after reset
    add_row(OP_EPOCH, 0, 0, 0, 0, 1'b1, STAGE_DEEP, 0, 0, 0);
    // zero rate is dropped, then the extremes of the rate range
    add_row(OP_HR, 0, 123, -5, 77, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_HR, 255, -32768, 32767, -1, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_HR, 1, 32767, -32768, 0, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_ACCEL, 255, 32767, -32768, 32767, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_ACCEL, 170, 0, 0, 0, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_ACCEL, 85, 4096, 0, 0, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_UNUSED, 255, -1, -1, -1, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_EPOCH, 255, -32768, -32768, -32768, 1'b0, STAGE_AWAKE, 0, 0, 0);
    // both edges of the default band around one g
    add_row(OP_ACCEL, 0, 4506, 0, 0, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_ACCEL, 0, 0, -4507, 0, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_ACCEL, 0, 0, 0, 3686, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_ACCEL, 0, 0, 0, -3685, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_EPOCH, 0, 0, 0, 0, 1'b1, STAGE_LIGHT, 0, 0, 2);
    add_row(OP_HR, 60, 0, 0, 0, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_HR, 60, 0, 0, 0, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_EPOCH, 0, 0, 0, 0, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_HR, 128, -200, 300, 4096, 1'b0, STAGE_AWAKE, 0, 0, 0);
    add_row(OP_EPOCH, 0, 0, 0, 0, 1'b1, STAGE_LIGHT, 128, 0, 0);

    foreach (dir_rows[i]) send_item(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].res);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results(1'b1);
      case (ph)
        0: apply_setting(13'd0, 13'd0, 13'd0, 13'h0040);
        1: apply_setting(13'h1FFF, 13'h00FF, 13'h00FF, 13'h0000);
        2: apply_setting(13'd4096, 13'd8, 13'd5, 13'h007D);
        // defaults again, with stray upper bits on the narrow registers
        3: apply_setting(13'd410, 13'h1F0F, 13'h1E03, 13'h1F7B);
        default: apply_setting(13'($urandom), 13'($urandom_range(2, 40)),
                               13'($urandom_range(0, 8)), 13'($urandom));
      endcase
      no_idle = (ph == 3);
      goal = stim_count + RANDOM_ITEMS / PHASES;
      first = 1'b1;
      while (stim_count < goal) begin
        send_epoch(first && ph == 2, first && ph == 0);
        first = 1'b0;
        if ($urandom_range(99) < 5) drain_results(1'b0);
      end
    end
    no_idle = 1'b0;

    drain_results(1'b0);
    repeat (END_CYCLES) @(posedge clk_i);
    $display("covered %0d input transactions and %0d epoch results", items_done, results_seen);
    $display("across %0d register settings, %0d mismatches", settings_used + 1, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
